/* rtl/core/adl_pkg.sv */
// adl_pkg: shared types and microcode program for the Adaline LMS trainer.
// Depends on nothing; used by adaline_lms_trainer.sv and the testbench.
`default_nettype none

package adl_pkg;

    localparam int MUL_A_W = 49;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = 57;
    localparam int PC_W    = 4;

    typedef enum logic [1:0] {
        CFG_LEARNING_RATE   = 2'd0,
        CFG_ERROR_THRESHOLD = 2'd1,
        CFG_MAX_EPOCHS      = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_TRAINING = 2'd0,
        ST_TRAINED  = 2'd1,
        ST_FAILED   = 2'd2
    } run_status_t;

    typedef enum logic [2:0] {
        A_W1,
        A_W2,
        A_ERR,
        A_PROD,
        A_ER,
        A_MAG
    } a_sel_t;

    typedef enum logic [2:0] {
        B_X1,
        B_X2,
        B_RATE,
        B_MAG_LO,
        B_MAG_HI
    } b_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_ACC_BIAS,
        OP_ACC_ADD,
        OP_NET_ERR,
        OP_MAG,
        OP_UPD_BIAS,
        OP_UPD_W1,
        OP_UPD_W2,
        OP_SQ_LO,
        OP_SQ_HI,
        OP_SUM_ADD,
        OP_EPOCH,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_HOLD_IN,
        C_FROZEN,
        C_NOT_LAST,
        C_HOLD_OUT
    } cond_t;

    typedef struct packed {
        a_sel_t          a_sel;
        b_sel_t          b_sel;
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_EPOCH = 4'd12;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd13;

    // product register always follows the operand selects of the current step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        begin
            case (pc)
                PC_START: uc = '{A_W1,   B_X1,     OP_LOAD_IN,  C_HOLD_IN,  PC_START};
                4'd1:  uc = '{A_W1,   B_X1,     OP_NONE,     C_NEXT,     PC_START};
                4'd2:  uc = '{A_W2,   B_X2,     OP_ACC_BIAS, C_NEXT,     PC_START};
                4'd3:  uc = '{A_W1,   B_X1,     OP_ACC_ADD,  C_NEXT,     PC_START};
                4'd4:  uc = '{A_W1,   B_X1,     OP_NET_ERR,  C_FROZEN,   PC_OUT};
                4'd5:  uc = '{A_ERR,  B_RATE,   OP_MAG,      C_NEXT,     PC_START};
                4'd6:  uc = '{A_PROD, B_X1,     OP_UPD_BIAS, C_NEXT,     PC_START};
                4'd7:  uc = '{A_ER,   B_X2,     OP_UPD_W1,   C_NEXT,     PC_START};
                4'd8:  uc = '{A_MAG,  B_MAG_LO, OP_UPD_W2,   C_NEXT,     PC_START};
                4'd9:  uc = '{A_MAG,  B_MAG_HI, OP_SQ_LO,    C_NEXT,     PC_START};
                4'd10: uc = '{A_W1,   B_X1,     OP_SQ_HI,    C_NEXT,     PC_START};
                4'd11: uc = '{A_W1,   B_X1,     OP_SUM_ADD,  C_NOT_LAST, PC_OUT};
                PC_EPOCH: uc = '{A_W1,   B_X1,     OP_EPOCH,    C_NEXT,     PC_START};
                PC_OUT:   uc = '{A_W1,   B_X1,     OP_OUT,      C_HOLD_OUT, PC_START};
                default: uc = '{A_W1, B_X1,     OP_NONE,     C_HOLD_OUT, PC_START};
            endcase
            return uc;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/adl_if.sv */
// adl_if: valid/ready channel interfaces for samples, results and register writes.
// Depends on nothing.
`default_nettype none

interface adl_smp_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] first_input;
    logic signed [7:0] second_input;
    logic signed [7:0] target_value;
    logic              epoch_end;

    modport source (output valid, first_input, second_input, target_value, epoch_end,
                    input ready);
    modport sink   (input valid, first_input, second_input, target_value, epoch_end,
                    output ready);
endinterface

interface adl_res_if;
    logic               valid;
    logic               ready;
    logic signed [1:0]  class_out;
    logic signed [31:0] net_sum;
    logic signed [23:0] weight_one_out;
    logic signed [23:0] weight_two_out;
    logic signed [23:0] bias_out;
    logic [31:0]        epoch_error;
    logic [1:0]         status;

    modport source (output valid, class_out, net_sum, weight_one_out, weight_two_out,
                    bias_out, epoch_error, status, input ready);
    modport sink   (input valid, class_out, net_sum, weight_one_out, weight_two_out,
                    bias_out, epoch_error, status, output ready);
endinterface

interface adl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/adaline_lms_trainer.sv */
// adaline_lms_trainer: two-input Adaline with LMS training, microcoded datapath.
// Depends on adl_pkg.sv and adl_if.sv.
//
//   channel  dir  word                                              handshake
//   smp      in   first_input, second_input, target_value, epoch_end valid/ready
//   res      out  class_out, net_sum, weights, epoch_error, status  valid/ready
//   cfg      in   index, data (register write)                      valid/ready
//
// One sample at a time through a 14-step program on one shared 49x17 multiplier:
// An epoch end adds the epoch step; once training is frozen the update steps are skipped.
// Result word sits in an output register; input is ready again the cycle after it loads.
// A stalled result holds the program at its last step. cfg is always ready.
// rst_n asynchronously restores weights (0.1), sums, counts and register defaults.
`default_nettype none

module adaline_lms_trainer #(
    parameter int FRAC_BITS = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    adl_smp_if.sink    smp,
    adl_res_if.source  res,
    adl_cfg_if.sink    cfg
);

    localparam logic signed [23:0] W_INIT = 24'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [23:0] W_MAX  = 24'sh7FFFFF;
    localparam logic signed [23:0] W_MIN  = -24'sh800000;

    function automatic logic signed [23:0] upd_weight(
        input logic signed [23:0]              w,
        input logic signed [adl_pkg::PROD_W-1:0] p
    );
        logic signed [adl_pkg::PROD_W-1:0] r;
        logic signed [adl_pkg::PROD_W-1:0] st;
        logic signed [41:0]                s;
        begin
            r  = p + adl_pkg::PROD_W'(32768);
            st = r >>> 16;
            s  = 42'(w) + st[41:0];
            if (s > 42'(W_MAX))
                return W_MAX;
            else if (s < 42'(W_MIN))
                return W_MIN;
            else
                return s[23:0];
        end
    endfunction

    adl_pkg::ucode_t uc;
    logic [adl_pkg::PC_W-1:0] pc_reg, pc_next;
    logic smp_acc, out_free;

    logic [15:0] rate_reg;
    logic [31:0] thr_reg;
    logic [7:0]  max_ep_reg;

    logic signed [23:0] w1_reg, w2_reg, bias_reg;
    logic [31:0]        sum_reg;
    logic [7:0]         epochs_reg;
    logic [1:0]         status_reg;
    logic               res_valid_reg;

    logic signed [7:0] x1_reg, x2_reg, t_reg;
    logic              last_reg;

    logic signed [adl_pkg::MUL_A_W-1:0] mul_a;
    logic signed [adl_pkg::MUL_B_W-1:0] mul_b;
    logic signed [adl_pkg::MUL_A_W+adl_pkg::MUL_B_W-1:0] mul_p;
    logic signed [adl_pkg::PROD_W-1:0]  prod_reg;
    logic signed [adl_pkg::MUL_A_W-1:0] er_reg;
    logic signed [33:0] acc_reg;
    logic signed [31:0] net_reg, net_next;
    logic signed [33:0] err_reg, err_next, err_abs;
    logic [31:0]        mag_reg, mag_next;
    logic [63:0]        sq_reg, sq_shift;
    logic [31:0]        sq_sat, sum_next, ep_err_reg, ep_err_next;
    logic [32:0]        sum_wide;
    logic [7:0]         epochs_next, limit;

    logic signed [1:0]  o_class_reg;
    logic signed [31:0] o_net_reg;
    logic signed [23:0] o_w1_reg, o_w2_reg, o_bias_reg;
    logic [31:0]        o_ep_reg;
    logic [1:0]         o_status_reg;

    always_comb
    begin
        uc        = adl_pkg::ucode_rom(pc_reg);
        smp.ready = (uc.cond == adl_pkg::C_HOLD_IN);
        smp_acc   = smp.valid && smp.ready;
        out_free  = !res_valid_reg || res.ready;
        case (uc.cond)
            adl_pkg::C_NEXT:     pc_next = pc_reg + 1'b1;
            adl_pkg::C_HOLD_IN:  pc_next = smp_acc ? pc_reg + 1'b1 : pc_reg;
            adl_pkg::C_FROZEN:   pc_next = (status_reg != adl_pkg::ST_TRAINING) ?
                                           uc.target : pc_reg + 1'b1;
            adl_pkg::C_NOT_LAST: pc_next = !last_reg ? uc.target : pc_reg + 1'b1;
            adl_pkg::C_HOLD_OUT: pc_next = out_free ? uc.target : pc_reg;
            default:             pc_next = adl_pkg::PC_START;
        endcase
    end

    // shared multiplier
    always_comb
    begin
        case (uc.a_sel)
            adl_pkg::A_W1:   mul_a = adl_pkg::MUL_A_W'(w1_reg);
            adl_pkg::A_W2:   mul_a = adl_pkg::MUL_A_W'(w2_reg);
            adl_pkg::A_ERR:  mul_a = adl_pkg::MUL_A_W'(err_reg);
            adl_pkg::A_PROD: mul_a = prod_reg[adl_pkg::MUL_A_W-1:0];
            adl_pkg::A_ER:   mul_a = er_reg;
            adl_pkg::A_MAG:  mul_a = adl_pkg::MUL_A_W'({1'b0, mag_reg});
            default:         mul_a = '0;
        endcase
        case (uc.b_sel)
            adl_pkg::B_X1:     mul_b = adl_pkg::MUL_B_W'(x1_reg);
            adl_pkg::B_X2:     mul_b = adl_pkg::MUL_B_W'(x2_reg);
            adl_pkg::B_RATE:   mul_b = {1'b0, rate_reg};
            adl_pkg::B_MAG_LO: mul_b = {1'b0, mag_reg[15:0]};
            adl_pkg::B_MAG_HI: mul_b = {1'b0, mag_reg[31:16]};
            default:           mul_b = '0;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        if (acc_reg > 34'sh07FFFFFFF)
            net_next = 32'sh7FFFFFFF;
        else if (acc_reg < -34'sh080000000)
            net_next = -32'sh80000000;
        else
            net_next = acc_reg[31:0];
        err_next = (34'(t_reg) <<< FRAC_BITS) - 34'(net_next);

        err_abs  = err_reg[33] ? -err_reg : err_reg;
        mag_next = (err_abs[33:32] != 2'b00) ? 32'hFFFFFFFF : err_abs[31:0];

        sq_shift = sq_reg >> FRAC_BITS;
        sq_sat   = (sq_shift[63:32] != 32'd0) ? 32'hFFFFFFFF : sq_shift[31:0];
        sum_wide = {1'b0, sum_reg} + {1'b0, sq_sat};
        sum_next = sum_wide[32] ? 32'hFFFFFFFF : sum_wide[31:0];

        ep_err_next = {1'b0, sum_reg[31:1]};
        epochs_next = (epochs_reg == 8'hFF) ? epochs_reg : epochs_reg + 1'b1;
        limit       = (max_ep_reg == 8'd0) ? 8'd1 : max_ep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= adl_pkg::PC_START;
            res_valid_reg <= 1'b0;
            rate_reg      <= 16'd6554;
            thr_reg       <= 32'd65536;
            max_ep_reg    <= 8'd5;
            w1_reg        <= W_INIT;
            w2_reg        <= W_INIT;
            bias_reg      <= W_INIT;
            sum_reg       <= '0;
            epochs_reg    <= '0;
            status_reg    <= adl_pkg::ST_TRAINING;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    adl_pkg::CFG_LEARNING_RATE:   rate_reg   <= cfg.data[15:0];
                    adl_pkg::CFG_ERROR_THRESHOLD: thr_reg    <= cfg.data;
                    adl_pkg::CFG_MAX_EPOCHS:      max_ep_reg <= cfg.data[7:0];
                    default: ;
                endcase
            end
            if ((uc.op == adl_pkg::OP_OUT) && out_free)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
            case (uc.op)
                adl_pkg::OP_UPD_BIAS: bias_reg <= upd_weight(bias_reg, prod_reg);
                adl_pkg::OP_UPD_W1:   w1_reg   <= upd_weight(w1_reg, prod_reg);
                adl_pkg::OP_UPD_W2:   w2_reg   <= upd_weight(w2_reg, prod_reg);
                adl_pkg::OP_SUM_ADD:  sum_reg  <= sum_next;
                adl_pkg::OP_EPOCH:
                begin
                    sum_reg    <= '0;
                    epochs_reg <= epochs_next;
                    if (ep_err_next <= thr_reg)
                        status_reg <= adl_pkg::ST_TRAINED;
                    else if (epochs_next >= limit)
                        status_reg <= adl_pkg::ST_FAILED;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[adl_pkg::PROD_W-1:0];
        case (uc.op)
            adl_pkg::OP_LOAD_IN:
            begin
                if (smp_acc)
                begin
                    x1_reg   <= smp.first_input;
                    x2_reg   <= smp.second_input;
                    t_reg    <= smp.target_value;
                    last_reg <= smp.epoch_end;
                end
            end
            adl_pkg::OP_ACC_BIAS: acc_reg <= 34'(bias_reg) + prod_reg[33:0];
            adl_pkg::OP_ACC_ADD:  acc_reg <= acc_reg + prod_reg[33:0];
            adl_pkg::OP_NET_ERR:
            begin
                net_reg    <= net_next;
                err_reg    <= err_next;
                ep_err_reg <= '0;
            end
            adl_pkg::OP_MAG:      mag_reg <= mag_next;
            adl_pkg::OP_UPD_BIAS: er_reg  <= prod_reg[adl_pkg::MUL_A_W-1:0];
            adl_pkg::OP_SQ_LO:    sq_reg  <= {16'd0, prod_reg[47:0]};
            adl_pkg::OP_SQ_HI:    sq_reg  <= sq_reg + {prod_reg[47:0], 16'd0};
            adl_pkg::OP_EPOCH:    ep_err_reg <= ep_err_next;
            adl_pkg::OP_OUT:
            begin
                if (out_free)
                begin
                    o_class_reg  <= (net_reg > 32'sd0) ? 2'sb01 : 2'sb11;
                    o_net_reg    <= net_reg;
                    o_w1_reg     <= w1_reg;
                    o_w2_reg     <= w2_reg;
                    o_bias_reg   <= bias_reg;
                    o_ep_reg     <= ep_err_reg;
                    o_status_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign cfg.ready          = 1'b1;
    assign res.valid          = res_valid_reg;
    assign res.class_out      = o_class_reg;
    assign res.net_sum        = o_net_reg;
    assign res.weight_one_out = o_w1_reg;
    assign res.weight_two_out = o_w2_reg;
    assign res.bias_out       = o_bias_reg;
    assign res.epoch_error    = o_ep_reg;
    assign res.status         = o_status_reg;

endmodule

`default_nettype wire
